// ===== hdl/sctm_pkg.sv =====
// ----------------------------------------------------------------------------
// sctm_pkg
// shared types and constants of the sector cache tag manager
// ----------------------------------------------------------------------------
`default_nettype none

package sctm_pkg;

   localparam int SLOTS = 15;
   localparam int SLOT_W = 4;
   localparam int TAG_W = 32;
   localparam int ERR_W = 2;

   localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(SLOTS);
   localparam logic [SLOT_W:0] SLOT_LIMIT_X = (SLOT_W + 1)'(SLOTS);
   localparam logic [ERR_W-1:0] ERR_NONE = '0;

   typedef enum logic {
      REQ_SECTOR = 1'b0,
      REQ_DONE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      OUT_HIT = 2'd0,
      OUT_REFETCH = 2'd1,
      OUT_FILL = 2'd2,
      OUT_DONE = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ALLOC
   } state_type;

   typedef struct packed {
      logic tag_we;
      logic err_we;
      logic [SLOT_W-1:0] addr;
      logic [TAG_W-1:0] tag;
      logic [ERR_W-1:0] err;
   } store_wr_type;

endpackage

`default_nettype wire

// ===== hdl/sctm_tag_store.sv =====
// ----------------------------------------------------------------------------
// sctm_tag_store
// slot tags and per-slot fetch status, one write and one read port
// ----------------------------------------------------------------------------
`default_nettype none

module sctm_tag_store
   import sctm_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire store_wr_type wr,
   input wire logic [SLOT_W-1:0] rd_addr,
   output logic [TAG_W-1:0] rd_tag,
   output logic [ERR_W-1:0] rd_err
);

   logic [TAG_W-1:0] tags_ff [SLOTS];
   logic [ERR_W-1:0] errs_ff [SLOTS];

   always_ff @(posedge clock) begin
      if (wr.tag_we) begin
         tags_ff[wr.addr] <= wr.tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            errs_ff[i] <= ERR_NONE;
         end
      end else if (wr.err_we) begin
         errs_ff[wr.addr] <= wr.err;
      end
   end

   assign rd_tag = tags_ff[rd_addr];
   assign rd_err = errs_ff[rd_addr];

endmodule

`default_nettype wire

// ===== hdl/sctm_seq.sv =====
// ----------------------------------------------------------------------------
// sctm_seq
// sequencer: slot scan over one shared tag comparator, allocation, results
// ----------------------------------------------------------------------------
`default_nettype none

module sctm_seq
   import sctm_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic req_type,
   input wire logic [TAG_W-1:0] req_sector,
   input wire logic [SLOT_W-1:0] req_done_slot,
   input wire logic [ERR_W-1:0] req_fetch_status,
   output logic rsp_valid,
   output logic [1:0] rsp_outcome,
   output logic [SLOT_W-1:0] rsp_result_slot,
   output store_wr_type wr,
   output logic [SLOT_W-1:0] rd_addr,
   input wire logic [TAG_W-1:0] rd_tag,
   input wire logic [ERR_W-1:0] rd_err
);

   state_type state_ff, state_in;
   logic [TAG_W-1:0] sector_ff, sector_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0] count_ff, count_in;
   logic [SLOT_W-1:0] ptr_ff, ptr_in;
   logic rsp_valid_ff, rsp_valid_in;
   outcome_type outcome_ff, outcome_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W:0] idx_next;
   logic [SLOT_W-1:0] victim;
   logic [SLOT_W:0] victim_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ptr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ptr_ff <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sector_ff <= sector_in;
      idx_ff <= idx_in;
      outcome_ff <= outcome_in;
      slot_ff <= slot_in;
   end

   assign idx_next = {1'b0, idx_ff} + 1'b1;
   assign victim = (count_ff < SLOT_LIMIT) ? count_ff :
                   ((ptr_ff >= SLOT_LIMIT) ? '0 : ptr_ff);
   assign victim_next = {1'b0, victim} + 1'b1;

   always_comb begin
      state_in = state_ff;
      sector_in = sector_ff;
      idx_in = idx_ff;
      count_in = count_ff;
      ptr_in = ptr_ff;
      rsp_valid_in = 1'b0;
      outcome_in = outcome_ff;
      slot_in = slot_ff;
      wr = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_type == REQ_DONE) begin
                  wr.err_we = (req_done_slot < SLOT_LIMIT);
                  wr.addr = req_done_slot;
                  wr.err = req_fetch_status;
                  rsp_valid_in = 1'b1;
                  outcome_in = OUT_DONE;
                  slot_in = req_done_slot;
               end else begin
                  sector_in = req_sector;
                  idx_in = '0;
                  state_in = (count_ff == '0) ? ST_ALLOC : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_tag == sector_ff) begin
               rsp_valid_in = 1'b1;
               slot_in = idx_ff;
               state_in = ST_IDLE;
               if (rd_err != ERR_NONE) begin
                  outcome_in = OUT_REFETCH;
                  wr.err_we = 1'b1;
                  wr.addr = idx_ff;
                  wr.err = ERR_NONE;
               end else begin
                  outcome_in = OUT_HIT;
               end
            end else if (idx_next >= {1'b0, count_ff}) begin
               state_in = ST_ALLOC;
            end else begin
               idx_in = idx_next[SLOT_W-1:0];
            end
         end
         ST_ALLOC: begin
            wr.tag_we = 1'b1;
            wr.err_we = 1'b1;
            wr.addr = victim;
            wr.tag = sector_ff;
            wr.err = ERR_NONE;
            if (count_ff < SLOT_LIMIT) begin
               count_in = count_ff + 1'b1;
            end else begin
               ptr_in = (victim_next >= SLOT_LIMIT_X) ? '0 : victim_next[SLOT_W-1:0];
            end
            rsp_valid_in = 1'b1;
            outcome_in = OUT_FILL;
            slot_in = victim;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign rd_addr = idx_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_outcome = outcome_ff;
   assign rsp_result_slot = slot_ff;

endmodule

`default_nettype wire

// ===== hdl/sector_cache_tag_manager.sv =====
// ----------------------------------------------------------------------------
// sector_cache_tag_manager
// tag manager of a fully associative cache of disk sectors, round-robin refill
//
//   channel   ports                                         handshake
//   request   req_type req_sector req_done_slot             start & !busy
//             req_fetch_status
//   result    rsp_outcome rsp_result_slot                   rsp_valid, one cycle
//
// a completion report does not raise busy
// a sector request raises busy while one 32-bit comparator checks one filled
// slot a cycle and, on a miss, while a slot is allocated
// the result strobes in the cycle busy falls; a new item may start then
// synchronous reset clears fetch status, fill count and replace pointer
// results cannot be stalled
// ----------------------------------------------------------------------------
`default_nettype none

module sector_cache_tag_manager
   import sctm_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire logic req_type,
   input wire logic [TAG_W-1:0] req_sector,
   input wire logic [SLOT_W-1:0] req_done_slot,
   input wire logic [ERR_W-1:0] req_fetch_status,
   output logic rsp_valid,
   output logic [1:0] rsp_outcome,
   output logic [SLOT_W-1:0] rsp_result_slot
);

   store_wr_type wr;
   logic [SLOT_W-1:0] rd_addr;
   logic [TAG_W-1:0] rd_tag;
   logic [ERR_W-1:0] rd_err;

   sctm_tag_store u_store (
      .clock(clock),
      .reset(reset),
      .wr(wr),
      .rd_addr(rd_addr),
      .rd_tag(rd_tag),
      .rd_err(rd_err)
   );

   sctm_seq u_seq (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_sector(req_sector),
      .req_done_slot(req_done_slot),
      .req_fetch_status(req_fetch_status),
      .rsp_valid(rsp_valid),
      .rsp_outcome(rsp_outcome),
      .rsp_result_slot(rsp_result_slot),
      .wr(wr),
      .rd_addr(rd_addr),
      .rd_tag(rd_tag),
      .rd_err(rd_err)
   );

   a_done_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == REQ_DONE) |=>
         (rsp_valid && rsp_outcome == OUT_DONE && rsp_result_slot == $past(req_done_slot)))
      else $error("completion item without matching result");

   a_sector_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == REQ_SECTOR) |=> (busy && !rsp_valid))
      else $error("sector item did not start a lookup");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome != OUT_DONE) |-> (rsp_result_slot < SLOT_LIMIT))
      else $error("lookup result names a slot out of range");

   a_lookup_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome != OUT_DONE) |-> (!busy && $past(busy)))
      else $error("lookup result outside the end of a lookup");

endmodule

`default_nettype wire
